// File: sv/tdo_pkg.sv
// ----------------------------------------------------------------------------
// tdo_pkg: shared types and constants
// Request, state and register codes, configuration reset values and the
// item, result and configuration structs of the dropoff sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package tdo_pkg;

  localparam int STEP_COUNT_BITS = 16;
  localparam logic [32:0] CNT_MAX = (33'd1 << STEP_COUNT_BITS) - 33'd1;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // request codes
  localparam logic [3:0] REQ_TICK      = 4'd0;
  localparam logic [3:0] REQ_UPDATE    = 4'd1;
  localparam logic [3:0] REQ_START     = 4'd2;
  localparam logic [3:0] REQ_JOG_START = 4'd3;
  localparam logic [3:0] REQ_JOG_STOP  = 4'd4;
  localparam logic [3:0] REQ_STOP_ALL  = 4'd5;
  localparam logic [3:0] REQ_SL_STEP   = 4'd6;
  localparam logic [3:0] REQ_ARM_STEP  = 4'd7;
  localparam logic [3:0] REQ_READ_CLR  = 4'd8;

  // sequencer states
  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_MANUAL     = 4'd1;
  localparam logic [3:0] ST_ARM_PRE    = 4'd2;
  localparam logic [3:0] ST_SLIDE      = 4'd3;
  localparam logic [3:0] ST_SLIDE_HOLD = 4'd4;
  localparam logic [3:0] ST_ARM_SIDE   = 4'd5;
  localparam logic [3:0] ST_ARM_HOLD   = 4'd6;
  localparam logic [3:0] ST_ARM_POST   = 4'd7;
  localparam logic [3:0] ST_DONE       = 4'd8;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SLIDER_OFFSET = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIDER_GAP    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_SIDE      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_MOVE      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_TARGET    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_SLIDER_HOLD   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_ARM_HOLD      = 3'd6;

  localparam logic [15:0] RST_SLIDER_OFFSET = 16'd1000;
  localparam logic [15:0] RST_SLIDER_GAP    = 16'd1000;
  localparam logic [15:0] RST_ARM_SIDE      = 16'd800;
  localparam logic [15:0] RST_MAX_MOVE      = 16'd65535;
  localparam logic [2:0]  RST_MAX_TARGET    = 3'd6;
  localparam logic [15:0] RST_SLIDER_HOLD   = 16'd500;
  localparam logic [15:0] RST_ARM_HOLD      = 16'd500;

  localparam logic [2:0] TARGET_LIMIT = 3'd6;

  typedef struct packed {
    logic [15:0] slider_offset_steps;
    logic [15:0] slider_gap_steps;
    logic [15:0] arm_side_steps;
    logic [15:0] max_move_steps;
    logic [2:0]  max_drop_tgt;
    logic [15:0] slider_hold_ms;
    logic [15:0] arm_hold_ms;
  } cfg_t;

  typedef struct packed {
    logic [3:0] req_type;
    logic [2:0] drop_tgt;
    logic       jog_dir;
  } item_t;

  typedef struct packed {
    logic       accepted;
    logic       done_flag;
    logic       busy_res;
    logic [3:0] seq_state;
    logic       slider_pulse_on;
    logic       slider_direction;
    logic       arm_pulse_on;
    logic       arm_direction;
  } res_t;

endpackage

// File: sv/tdo_if.sv
// ----------------------------------------------------------------------------
// tdo_if: item channels of the dropoff sequencer
// Request channel and result channel, each with valid, ready and payload.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface tdo_in_if;
  logic       valid;
  logic       ready;
  logic [3:0] req_type;
  logic [2:0] drop_tgt;
  logic       jog_dir;

  modport source (output valid, output req_type, output drop_tgt, output jog_dir,
                  input ready);
  modport sink (input valid, input req_type, input drop_tgt, input jog_dir,
                output ready);
endinterface

interface tdo_out_if;
  logic       valid;
  logic       ready;
  logic       accepted;
  logic       done_flag;
  logic       busy_res;
  logic [3:0] seq_state;
  logic       slider_pulse_on;
  logic       slider_direction;
  logic       arm_pulse_on;
  logic       arm_direction;

  modport source (output valid, output accepted, output done_flag, output busy_res,
                  output seq_state, output slider_pulse_on, output slider_direction,
                  output arm_pulse_on, output arm_direction, input ready);
  modport sink (input valid, input accepted, input done_flag, input busy_res,
                input seq_state, input slider_pulse_on, input slider_direction,
                input arm_pulse_on, input arm_direction, output ready);
endinterface

// File: sv/tdo_cfg_regs.sv
// ----------------------------------------------------------------------------
// tdo_cfg_regs: configuration registers
// Write-only register file holding the position, limit and timing settings.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdo_cfg_regs (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [tdo_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [tdo_pkg::CFG_DATA_W-1:0]   cfg_wdata,
  output tdo_pkg::cfg_t                    cfg
);
  import tdo_pkg::*;

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_idx)
        CFG_SLIDER_OFFSET: cfg_nxt.slider_offset_steps = cfg_wdata;
        CFG_SLIDER_GAP:    cfg_nxt.slider_gap_steps    = cfg_wdata;
        CFG_ARM_SIDE:      cfg_nxt.arm_side_steps      = cfg_wdata;
        CFG_MAX_MOVE:      cfg_nxt.max_move_steps      = cfg_wdata;
        CFG_MAX_TARGET:    cfg_nxt.max_drop_tgt        = cfg_wdata[2:0];
        CFG_SLIDER_HOLD:   cfg_nxt.slider_hold_ms      = cfg_wdata;
        CFG_ARM_HOLD:      cfg_nxt.arm_hold_ms         = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.slider_offset_steps <= RST_SLIDER_OFFSET;
      cfg_r.slider_gap_steps    <= RST_SLIDER_GAP;
      cfg_r.arm_side_steps      <= RST_ARM_SIDE;
      cfg_r.max_move_steps      <= RST_MAX_MOVE;
      cfg_r.max_drop_tgt        <= RST_MAX_TARGET;
      cfg_r.slider_hold_ms      <= RST_SLIDER_HOLD;
      cfg_r.arm_hold_ms         <= RST_ARM_HOLD;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// File: sv/tdo_seq_core.sv
// ----------------------------------------------------------------------------
// tdo_seq_core: sequencer state and next-state logic
// Applies one request item per cycle in which fire is high to the axis and
// sequence state and forms the status result from the updated state.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tdo_seq_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           fire,
  input  tdo_pkg::item_t item,
  input  tdo_pkg::cfg_t  cfg,
  output tdo_pkg::res_t  res
);
  import tdo_pkg::*;

  localparam int SCB = STEP_COUNT_BITS;

  logic [3:0]     state_r, state_nxt;
  logic           sl_mv_r, sl_mv_nxt;
  logic           arm_mv_r, arm_mv_nxt;
  logic [SCB-1:0] sl_cnt_r, sl_cnt_nxt;
  logic [SCB-1:0] arm_cnt_r, arm_cnt_nxt;
  logic [1:0]     sl_pos_r, sl_pos_nxt;
  logic [1:0]     arm_pos_r, arm_pos_nxt;
  logic [1:0]     sl_goal_r, sl_goal_nxt;
  logic [1:0]     arm_goal_r, arm_goal_nxt;
  logic           done_r, done_nxt;
  logic [2:0]     target_r, target_nxt;
  logic [31:0]    millis_r, millis_nxt;
  logic [31:0]    hold_r, hold_nxt;
  logic           sl_dir_r, sl_dir_nxt;
  logic           arm_dir_r, arm_dir_nxt;

  logic           acc;
  logic           dflag;

  logic [2:0]     tgt_lim;
  logic           start_ok;
  logic [2:0]     tid_m1;
  logic [1:0]     start_goal;
  logic [1:0]     side_idx;
  logic [1:0]     sl_goal_use;
  logic [1:0]     arm_goal_use;
  logic signed [18:0] sl_delta;
  logic signed [17:0] arm_delta;
  logic           sl_nz, arm_nz;
  logic [18:0]    sl_mag;
  logic [18:0]    arm_mag;
  logic [SCB-1:0] sl_load, arm_load;
  logic [31:0]    elapsed;
  logic [15:0]    hold_lim;
  logic           hold_ok;
  logic [SCB-1:0] sl_dec, arm_dec;

  function automatic logic [17:0] slider_pos(input cfg_t c, input logic [1:0] idx);
    logic [17:0] off;
    logic [17:0] gap;
    logic [17:0] p;
    off = {2'b00, c.slider_offset_steps};
    gap = {2'b00, c.slider_gap_steps};
    case (idx)
      2'd1:    p = off;
      2'd2:    p = off + gap;
      2'd3:    p = off + {gap[16:0], 1'b0};
      default: p = 18'd0;
    endcase
    return p;
  endfunction

  function automatic logic signed [17:0] arm_pos(input cfg_t c, input logic [1:0] idx);
    logic signed [17:0] s;
    logic signed [17:0] p;
    s = signed'({2'b00, c.arm_side_steps});
    case (idx)
      2'd1:    p = -s;
      2'd2:    p = s;
      default: p = 18'sd0;
    endcase
    return p;
  endfunction

  function automatic logic [SCB-1:0] clamp_cnt(input logic [18:0] m,
                                               input logic [15:0] mm);
    logic [15:0] m16;
    logic [32:0] m33;
    m16 = (m > {3'b000, mm}) ? mm : m[15:0];
    m33 = {17'd0, m16};
    if (m33 > CNT_MAX) begin
      m33 = CNT_MAX;
    end
    return m33[SCB-1:0];
  endfunction

  always_comb begin
    tgt_lim    = (cfg.max_drop_tgt > TARGET_LIMIT) ? TARGET_LIMIT : cfg.max_drop_tgt;
    start_ok   = (state_r == ST_IDLE) && (item.drop_tgt <= tgt_lim);
    tid_m1     = item.drop_tgt - 3'd1;
    start_goal = (item.drop_tgt == 3'd0) ? 2'd0 : (tid_m1[2:1] + 2'd1);
    side_idx   = target_r[0] ? 2'd1 : 2'd2;

    sl_goal_use  = (item.req_type == REQ_START) ? start_goal : sl_goal_r;
    arm_goal_use = (item.req_type == REQ_UPDATE && state_r == ST_SLIDE_HOLD) ?
                   side_idx : 2'd0;

    sl_delta  = signed'({1'b0, slider_pos(cfg, sl_goal_use)}) -
                signed'({1'b0, slider_pos(cfg, sl_pos_r)});
    arm_delta = arm_pos(cfg, arm_goal_use) - arm_pos(cfg, arm_pos_r);
    sl_nz     = (sl_delta != 19'sd0);
    arm_nz    = (arm_delta != 18'sd0);
    sl_mag    = sl_delta[18] ? 19'(-sl_delta) : 19'(sl_delta);
    arm_mag   = arm_delta[17] ? {1'b0, 18'(-arm_delta)} : {1'b0, 18'(arm_delta)};
    sl_load   = clamp_cnt(sl_mag, cfg.max_move_steps);
    arm_load  = clamp_cnt(arm_mag, cfg.max_move_steps);

    elapsed  = millis_r - hold_r;
    hold_lim = (state_r == ST_SLIDE_HOLD) ? cfg.slider_hold_ms : cfg.arm_hold_ms;
    hold_ok  = (elapsed >= {16'd0, hold_lim});

    sl_dec  = (sl_cnt_r != '0) ? sl_cnt_r - SCB'(1) : sl_cnt_r;
    arm_dec = (arm_cnt_r != '0) ? arm_cnt_r - SCB'(1) : arm_cnt_r;
  end

  always_comb begin
    state_nxt    = state_r;
    sl_mv_nxt    = sl_mv_r;
    arm_mv_nxt   = arm_mv_r;
    sl_cnt_nxt   = sl_cnt_r;
    arm_cnt_nxt  = arm_cnt_r;
    sl_pos_nxt   = sl_pos_r;
    arm_pos_nxt  = arm_pos_r;
    sl_goal_nxt  = sl_goal_r;
    arm_goal_nxt = arm_goal_r;
    done_nxt     = done_r;
    target_nxt   = target_r;
    millis_nxt   = millis_r;
    hold_nxt     = hold_r;
    sl_dir_nxt   = sl_dir_r;
    arm_dir_nxt  = arm_dir_r;
    acc          = 1'b0;
    dflag        = 1'b0;

    case (item.req_type)
      REQ_TICK: millis_nxt = millis_r + 32'd1;
      REQ_UPDATE: begin
        case (state_r)
          ST_IDLE, ST_MANUAL: ;
          ST_ARM_PRE: begin
            if (!arm_mv_r) begin
              arm_pos_nxt = 2'd0;
              if (sl_nz && !sl_mv_r) begin
                sl_dir_nxt = !sl_delta[18];
                sl_cnt_nxt = sl_load;
                sl_mv_nxt  = 1'b1;
              end
              state_nxt = ST_SLIDE;
            end
          end
          ST_SLIDE: begin
            if (!sl_mv_r) begin
              sl_pos_nxt = sl_goal_r;
              hold_nxt   = millis_r;
              state_nxt  = ST_SLIDE_HOLD;
            end
          end
          ST_SLIDE_HOLD: begin
            if (hold_ok) begin
              if (target_r == 3'd0) begin
                state_nxt = ST_DONE;
              end else begin
                arm_goal_nxt = side_idx;
                if (arm_nz) begin
                  if (!arm_mv_r) begin
                    arm_dir_nxt = !arm_delta[17];
                    arm_cnt_nxt = arm_load;
                    arm_mv_nxt  = 1'b1;
                  end
                  state_nxt = ST_ARM_SIDE;
                end else begin
                  state_nxt = ST_DONE;
                end
              end
            end
          end
          ST_ARM_SIDE: begin
            if (!arm_mv_r) begin
              arm_pos_nxt = arm_goal_r;
              hold_nxt    = millis_r;
              state_nxt   = ST_ARM_HOLD;
            end
          end
          ST_ARM_HOLD: begin
            if (hold_ok) begin
              arm_goal_nxt = 2'd0;
              if (arm_nz) begin
                if (!arm_mv_r) begin
                  arm_dir_nxt = !arm_delta[17];
                  arm_cnt_nxt = arm_load;
                  arm_mv_nxt  = 1'b1;
                end
                state_nxt = ST_ARM_POST;
              end else begin
                state_nxt = ST_DONE;
              end
            end
          end
          ST_ARM_POST: begin
            if (!arm_mv_r) begin
              arm_pos_nxt = 2'd0;
              state_nxt   = ST_DONE;
            end
          end
          ST_DONE: begin
            done_nxt  = 1'b1;
            state_nxt = ST_IDLE;
          end
          default: state_nxt = ST_IDLE;
        endcase
      end
      REQ_START: begin
        if (start_ok) begin
          acc          = 1'b1;
          sl_goal_nxt  = start_goal;
          target_nxt   = item.drop_tgt;
          done_nxt     = 1'b0;
          hold_nxt     = 32'd0;
          arm_goal_nxt = 2'd0;
          if (arm_nz) begin
            if (!arm_mv_r) begin
              arm_dir_nxt = !arm_delta[17];
              arm_cnt_nxt = arm_load;
              arm_mv_nxt  = 1'b1;
            end
            state_nxt = ST_ARM_PRE;
          end else begin
            arm_pos_nxt = 2'd0;
            if (sl_nz && !sl_mv_r) begin
              sl_dir_nxt = !sl_delta[18];
              sl_cnt_nxt = sl_load;
              sl_mv_nxt  = 1'b1;
            end
            state_nxt = ST_SLIDE;
          end
        end
      end
      REQ_JOG_START: begin
        if (state_r == ST_IDLE && !sl_mv_r) begin
          sl_dir_nxt = item.jog_dir;
          sl_cnt_nxt = '0;
          sl_mv_nxt  = 1'b1;
          state_nxt  = ST_MANUAL;
        end
      end
      REQ_JOG_STOP: begin
        if (state_r == ST_MANUAL) begin
          sl_cnt_nxt  = '0;
          sl_mv_nxt   = 1'b0;
          sl_pos_nxt  = 2'd0;
          sl_goal_nxt = 2'd0;
          state_nxt   = ST_IDLE;
        end
      end
      REQ_STOP_ALL: begin
        sl_cnt_nxt  = '0;
        arm_cnt_nxt = '0;
        sl_mv_nxt   = 1'b0;
        arm_mv_nxt  = 1'b0;
        state_nxt   = ST_IDLE;
        done_nxt    = 1'b0;
        target_nxt  = 3'd0;
        hold_nxt    = 32'd0;
      end
      REQ_SL_STEP: begin
        if (sl_mv_r && state_r != ST_MANUAL) begin
          sl_cnt_nxt = sl_dec;
          if (sl_dec == '0) begin
            sl_mv_nxt = 1'b0;
          end
        end
      end
      REQ_ARM_STEP: begin
        if (arm_mv_r) begin
          arm_cnt_nxt = arm_dec;
          if (arm_dec == '0) begin
            arm_mv_nxt = 1'b0;
          end
        end
      end
      REQ_READ_CLR: begin
        dflag    = done_r;
        done_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      sl_mv_r    <= 1'b0;
      arm_mv_r   <= 1'b0;
      sl_cnt_r   <= '0;
      arm_cnt_r  <= '0;
      sl_pos_r   <= 2'd0;
      arm_pos_r  <= 2'd0;
      sl_goal_r  <= 2'd0;
      arm_goal_r <= 2'd0;
      done_r     <= 1'b0;
      target_r   <= 3'd0;
      millis_r   <= 32'd0;
      hold_r     <= 32'd0;
      sl_dir_r   <= 1'b0;
      arm_dir_r  <= 1'b0;
    end else if (fire) begin
      state_r    <= state_nxt;
      sl_mv_r    <= sl_mv_nxt;
      arm_mv_r   <= arm_mv_nxt;
      sl_cnt_r   <= sl_cnt_nxt;
      arm_cnt_r  <= arm_cnt_nxt;
      sl_pos_r   <= sl_pos_nxt;
      arm_pos_r  <= arm_pos_nxt;
      sl_goal_r  <= sl_goal_nxt;
      arm_goal_r <= arm_goal_nxt;
      done_r     <= done_nxt;
      target_r   <= target_nxt;
      millis_r   <= millis_nxt;
      hold_r     <= hold_nxt;
      sl_dir_r   <= sl_dir_nxt;
      arm_dir_r  <= arm_dir_nxt;
    end
  end

  always_comb begin
    res.accepted         = acc;
    res.done_flag        = dflag;
    res.busy_res         = (state_nxt != ST_IDLE);
    res.seq_state        = state_nxt;
    res.slider_pulse_on  = sl_mv_nxt;
    res.slider_direction = sl_dir_nxt;
    res.arm_pulse_on     = arm_mv_nxt;
    res.arm_direction    = arm_dir_nxt;
  end

endmodule

// File: sv/two_axis_dropoff_sequencer.sv
// ----------------------------------------------------------------------------
// two_axis_dropoff_sequencer: slider and arm dropoff sequencer
// Request items drive a two-axis dropoff sequence; every item returns one
// status result.
//
// Channels: in_ch carries request items (req_type, drop_tgt, jog_dir);
// out_ch returns one result item per request with the status after it.
// cfg_we/cfg_idx/cfg_wdata write the seven settings registers. The user must
// have them taken only while no item is in flight; the block does not enforce it.
// Path: a request accepted on in_ch passes the input register, then the result
// register before its result is valid on out_ch. Throughput: one item per cycle
// while out_ch is not stalled; the state update for one item is a single pass
// of the next-state logic between the input register and the result register.
// Reset: sequencer idle, axes stopped, counters and clock cleared, settings
// at their defaults.
// Stall: when out_ch.ready is low the result holds; one more request is
// taken into the input register, then in_ch.ready drops until the result
// is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module two_axis_dropoff_sequencer (
  input  logic                           clk,
  input  logic                           rst_n,
  tdo_in_if.sink                         in_ch,
  tdo_out_if.source                      out_ch,
  input  logic                           cfg_we,
  input  logic [tdo_pkg::CFG_IDX_W-1:0]  cfg_idx,
  input  logic [tdo_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tdo_pkg::*;

  cfg_t  cfg;
  item_t in_item_r;
  logic  in_vld_r;
  res_t  res;
  res_t  out_res_r;
  logic  out_vld_r;
  logic  out_adv;
  logic  fire;

  assign out_adv     = !out_vld_r || out_ch.ready;
  assign fire        = in_vld_r && out_adv;
  assign in_ch.ready = !in_vld_r || out_adv;

  tdo_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tdo_seq_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (in_item_r),
    .cfg   (cfg),
    .res   (res)
  );

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      in_item_r.req_type <= in_ch.req_type;
      in_item_r.drop_tgt <= in_ch.drop_tgt;
      in_item_r.jog_dir  <= in_ch.jog_dir;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_adv) begin
      out_vld_r <= in_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_res_r <= res;
    end
  end

  assign out_ch.valid            = out_vld_r;
  assign out_ch.accepted         = out_res_r.accepted;
  assign out_ch.done_flag        = out_res_r.done_flag;
  assign out_ch.busy_res         = out_res_r.busy_res;
  assign out_ch.seq_state        = out_res_r.seq_state;
  assign out_ch.slider_pulse_on  = out_res_r.slider_pulse_on;
  assign out_ch.slider_direction = out_res_r.slider_direction;
  assign out_ch.arm_pulse_on     = out_res_r.arm_pulse_on;
  assign out_ch.arm_direction    = out_res_r.arm_direction;

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !out_adv) |=> (in_vld_r && $stable(in_item_r)))
    else $error("pending request item lost while result stalled");

  a_acc_state: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_res_r.accepted) |->
      (!out_res_r.done_flag && out_res_r.busy_res &&
       (out_res_r.seq_state == ST_ARM_PRE || out_res_r.seq_state == ST_SLIDE)))
    else $error("accepted start without a started sequence");

  a_dflag_req: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && in_item_r.req_type != REQ_READ_CLR) |=> !out_res_r.done_flag)
    else $error("done flag reported on a request other than read-clear");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && res.busy_res) |=> (out_vld_r && out_res_r.seq_state != ST_IDLE))
    else $error("busy result with idle state code");

endmodule

// File: sim/tb_two_axis_dropoff_sequencer.sv
// ----------------------------------------------------------------------------
// tb_two_axis_dropoff_sequencer: self-checking bench for the dropoff sequencer
// Drives request items through several register settings: a directed pass
// over every request type and corner case, then random dropoff and jog
// sequences. A behavioral status model predicts each result, which is checked
// field by field, while both channels stall at random in all but one phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_two_axis_dropoff_sequencer;
  import tdo_pkg::*;

  localparam logic [3:0] REQ_UNUSED_LO = 4'd9;
  localparam logic [3:0] REQ_UNUSED_HI = 4'd15;
  localparam int IDLE_PCT = 32;

  logic clk = 1'b0;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  tdo_in_if in_if ();
  tdo_out_if out_if ();

  two_axis_dropoff_sequencer uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_if),
    .out_ch   (out_if),
    .cfg_we   (cfg_we),
    .cfg_idx  (cfg_idx),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // settings copy
  logic [15:0] p_offset, p_gap, p_side, p_cap, p_slide_ms, p_arm_ms;
  logic [2:0]  p_tmax;

  // sequencer copy
  logic [3:0]  st;
  logic        sl_run, arm_run, done_q, sl_dir, arm_dir;
  logic [15:0] sl_left, arm_left;
  logic [1:0]  sl_at, arm_at, sl_goal, arm_goal;
  logic [2:0]  job;
  logic [31:0] ms_now, t0;

  item_t request_q[$];
  res_t  status_q[$];
  item_t drv_item, seen_item;
  res_t  got, want;
  logic  in_took;
  logic  calm;
  int    queued, taken, checked, errors, settings, n_accepted, n_done;

  function automatic int slider_pos(input logic [1:0] i);
    int off;
    int gap;
    off = p_offset;
    gap = p_gap;
    case (i)
      2'd1: return off;
      2'd2: return off + gap;
      2'd3: return off + 2 * gap;
      default: return 0;
    endcase
  endfunction

  function automatic int arm_pos(input logic [1:0] i);
    int side;
    side = p_side;
    case (i)
      2'd1: return -side;
      2'd2: return side;
      default: return 0;
    endcase
  endfunction

  function automatic int slider_delta();
    return slider_pos(sl_goal) - slider_pos(sl_at);
  endfunction

  function automatic int arm_delta();
    return arm_pos(arm_goal) - arm_pos(arm_at);
  endfunction

  function automatic logic [15:0] step_budget(input int d);
    int m;
    int cap;
    cap = p_cap;
    m = (d < 0) ? -d : d;
    if (m > cap) m = cap;
    if (m > 65535) m = 65535;
    return m[15:0];
  endfunction

  function automatic void slider_cmd(input int d);
    if (d == 0 || sl_run) return;
    sl_dir  = (d > 0);
    sl_left = step_budget(d);
    sl_run  = 1'b1;
  endfunction

  function automatic void arm_cmd(input int d);
    if (d == 0 || arm_run) return;
    arm_dir  = (d > 0);
    arm_left = step_budget(d);
    arm_run  = 1'b1;
  endfunction

  function automatic void advance_sequence();
    case (st)
      ST_IDLE, ST_MANUAL: begin
      end
      ST_ARM_PRE: begin
        if (!arm_run) begin
          arm_at = 2'd0;
          slider_cmd(slider_delta());
          st = ST_SLIDE;
        end
      end
      ST_SLIDE: begin
        if (!sl_run) begin
          sl_at = sl_goal;
          t0 = ms_now;
          st = ST_SLIDE_HOLD;
        end
      end
      ST_SLIDE_HOLD: begin
        if (ms_now - t0 >= {16'd0, p_slide_ms}) begin
          if (job == 3'd0) begin
            st = ST_DONE;
          end else begin
            arm_goal = job[0] ? 2'd1 : 2'd2;
            if (arm_delta() != 0) begin
              arm_cmd(arm_delta());
              st = ST_ARM_SIDE;
            end else begin
              st = ST_DONE;
            end
          end
        end
      end
      ST_ARM_SIDE: begin
        if (!arm_run) begin
          arm_at = arm_goal;
          t0 = ms_now;
          st = ST_ARM_HOLD;
        end
      end
      ST_ARM_HOLD: begin
        if (ms_now - t0 >= {16'd0, p_arm_ms}) begin
          arm_goal = 2'd0;
          if (arm_delta() != 0) begin
            arm_cmd(arm_delta());
            st = ST_ARM_POST;
          end else begin
            st = ST_DONE;
          end
        end
      end
      ST_ARM_POST: begin
        if (!arm_run) begin
          arm_at = 2'd0;
          st = ST_DONE;
        end
      end
      ST_DONE: begin
        done_q = 1'b1;
        st = ST_IDLE;
      end
      default: st = ST_IDLE;
    endcase
  endfunction

  function automatic logic begin_dropoff(input logic [2:0] t);
    logic [2:0] lim;
    logic [2:0] tm;
    lim = (p_tmax > TARGET_LIMIT) ? TARGET_LIMIT : p_tmax;
    if (st != ST_IDLE || t > lim) return 1'b0;
    tm = t - 3'd1;
    sl_goal = (t == 3'd0) ? 2'd0 : tm[2:1] + 2'd1;
    job = t;
    done_q = 1'b0;
    t0 = '0;
    arm_goal = 2'd0;
    if (arm_delta() != 0) begin
      arm_cmd(arm_delta());
      st = ST_ARM_PRE;
    end else begin
      arm_at = 2'd0;
      slider_cmd(slider_delta());
      st = ST_SLIDE;
    end
    return 1'b1;
  endfunction

  function automatic res_t predict_status(input item_t it);
    res_t r;
    r = '0;
    case (it.req_type)
      REQ_TICK: ms_now = ms_now + 32'd1;
      REQ_UPDATE: advance_sequence();
      REQ_START: r.accepted = begin_dropoff(it.drop_tgt);
      REQ_JOG_START: begin
        if (st == ST_IDLE && !sl_run) begin
          sl_dir = it.jog_dir;
          sl_left = '0;
          sl_run = 1'b1;
          st = ST_MANUAL;
        end
      end
      REQ_JOG_STOP: begin
        if (st == ST_MANUAL) begin
          sl_left = '0;
          sl_run = 1'b0;
          sl_at = 2'd0;
          sl_goal = 2'd0;
          st = ST_IDLE;
        end
      end
      REQ_STOP_ALL: begin
        sl_left = '0;
        arm_left = '0;
        sl_run = 1'b0;
        arm_run = 1'b0;
        st = ST_IDLE;
        done_q = 1'b0;
        job = '0;
        t0 = '0;
      end
      REQ_SL_STEP: begin
        if (sl_run && st != ST_MANUAL) begin
          if (sl_left != 0) sl_left = sl_left - 16'd1;
          if (sl_left == 0) sl_run = 1'b0;
        end
      end
      REQ_ARM_STEP: begin
        if (arm_run) begin
          if (arm_left != 0) arm_left = arm_left - 16'd1;
          if (arm_left == 0) arm_run = 1'b0;
        end
      end
      REQ_READ_CLR: begin
        r.done_flag = done_q;
        done_q = 1'b0;
      end
      default: begin
      end
    endcase
    r.busy_res = (st != ST_IDLE);
    r.seq_state = st;
    r.slider_pulse_on = sl_run;
    r.slider_direction = sl_dir;
    r.arm_pulse_on = arm_run;
    r.arm_direction = arm_dir;
    return r;
  endfunction

  function automatic void store_reg(input logic [2:0] idx, input logic [15:0] v);
    case (idx)
      CFG_SLIDER_OFFSET: p_offset = v;
      CFG_SLIDER_GAP: p_gap = v;
      CFG_ARM_SIDE: p_side = v;
      CFG_MAX_MOVE: p_cap = v;
      CFG_MAX_TARGET: p_tmax = v[2:0];
      CFG_SLIDER_HOLD: p_slide_ms = v;
      CFG_ARM_HOLD: p_arm_ms = v;
      default: begin
      end
    endcase
  endfunction

  task automatic note_mismatch(input string msg);
    errors++;
    $display("ERROR at %0t ns, result %0d: %s", $time, checked, msg);
  endtask

  task automatic check_field(input string name, input logic [3:0] got_v,
                             input logic [3:0] want_v);
    if (got_v !== want_v)
      note_mismatch($sformatf("%s is %0d, predicted %0d", name, got_v, want_v));
  endtask

  // driver: present the next item once the current one is taken
  always @(negedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
    end else if (!in_if.valid || in_took) begin
      if (request_q.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
        drv_item = request_q.pop_front();
        in_if.valid <= 1'b1;
        in_if.req_type <= drv_item.req_type;
        in_if.drop_tgt <= drv_item.drop_tgt;
        in_if.jog_dir <= drv_item.jog_dir;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
    out_if.ready <= rst_n && (calm || $urandom_range(99) >= IDLE_PCT);
  end

  // monitor: predict on each accepted item, check each accepted result
  always @(posedge clk) begin
    in_took <= rst_n && in_if.valid && in_if.ready;
    if (rst_n) begin
      if (out_if.valid && out_if.ready) begin
        got.accepted = out_if.accepted;
        got.done_flag = out_if.done_flag;
        got.busy_res = out_if.busy_res;
        got.seq_state = out_if.seq_state;
        got.slider_pulse_on = out_if.slider_pulse_on;
        got.slider_direction = out_if.slider_direction;
        got.arm_pulse_on = out_if.arm_pulse_on;
        got.arm_direction = out_if.arm_direction;
        if (status_q.size() == 0) begin
          note_mismatch("result arrived with none pending");
        end else begin
          want = status_q.pop_front();
          check_field("accepted", got.accepted, want.accepted);
          check_field("done_flag", got.done_flag, want.done_flag);
          check_field("busy_res", got.busy_res, want.busy_res);
          check_field("seq_state", got.seq_state, want.seq_state);
          check_field("slider_pulse_on", got.slider_pulse_on, want.slider_pulse_on);
          check_field("slider_direction", got.slider_direction, want.slider_direction);
          check_field("arm_pulse_on", got.arm_pulse_on, want.arm_pulse_on);
          check_field("arm_direction", got.arm_direction, want.arm_direction);
          n_accepted += want.accepted;
          n_done += want.done_flag;
        end
        checked++;
      end
      if (in_if.valid && in_if.ready) begin
        seen_item.req_type = in_if.req_type;
        seen_item.drop_tgt = in_if.drop_tgt;
        seen_item.jog_dir = in_if.jog_dir;
        status_q.push_back(predict_status(seen_item));
        taken++;
      end
    end
  end

  task automatic push(input logic [3:0] req, input logic [2:0] tid, input logic jdir);
    item_t it;
    it.req_type = req;
    it.drop_tgt = tid;
    it.jog_dir = jdir;
    request_q.push_back(it);
    queued++;
  endtask

  task automatic push_any(input logic [3:0] req);
    push(req, 3'($urandom_range(7)), 1'($urandom_range(1)));
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] v);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v;
    store_reg(idx, v);
  endtask

  task automatic load_settings(input logic [15:0] off, gap, side, cap,
                               input logic [2:0] tmax, input logic [15:0] shold, ahold);
    write_reg(CFG_SLIDER_OFFSET, off);
    write_reg(CFG_SLIDER_GAP, gap);
    write_reg(CFG_ARM_SIDE, side);
    write_reg(CFG_MAX_MOVE, cap);
    write_reg(CFG_MAX_TARGET, {13'd0, tmax});
    write_reg(CFG_SLIDER_HOLD, shold);
    write_reg(CFG_ARM_HOLD, ahold);
    @(negedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  task automatic wait_drain();
    while (taken != queued || status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic dropoff_episode();
    int pick;
    push_any(REQ_START);
    repeat ($urandom_range(18, 40)) begin
      pick = $urandom_range(99);
      if (pick < 34) push_any(REQ_UPDATE);
      else if (pick < 54) push_any(REQ_SL_STEP);
      else if (pick < 74) push_any(REQ_ARM_STEP);
      else if (pick < 90) push_any(REQ_TICK);
      else if (pick < 93) push_any(REQ_READ_CLR);
      else if (pick < 95) push_any(REQ_START);
      else if (pick < 96) push_any(REQ_STOP_ALL);
      else if (pick < 97) push_any(REQ_JOG_START);
      else if (pick < 98) push_any(REQ_JOG_STOP);
      else push_any(4'($urandom_range(REQ_UNUSED_LO, REQ_UNUSED_HI)));
    end
    push_any(REQ_READ_CLR);
  endtask

  task automatic jog_episode();
    int pick;
    push_any(REQ_JOG_START);
    repeat ($urandom_range(1, 6)) begin
      pick = $urandom_range(3);
      case (pick)
        0: push_any(REQ_SL_STEP);
        1: push_any(REQ_TICK);
        2: push_any(REQ_UPDATE);
        default: push_any(REQ_ARM_STEP);
      endcase
    end
    push_any(REQ_JOG_STOP);
  endtask

  task automatic run_phase(input int n);
    int first;
    first = queued;
    push_any(REQ_STOP_ALL);
    while (queued - first < n) begin
      if ($urandom_range(99) < 15) jog_episode();
      else dropoff_episode();
    end
    wait_drain();
  endtask

  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_idx = '0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_TICK;
    in_if.drop_tgt = '0;
    in_if.jog_dir = 1'b0;
    out_if.ready = 1'b0;
    in_took = 1'b0;
    calm = 1'b0;
    queued = 0;
    taken = 0;
    checked = 0;
    errors = 0;
    settings = 1;
    n_accepted = 0;
    n_done = 0;
    p_offset = RST_SLIDER_OFFSET;
    p_gap = RST_SLIDER_GAP;
    p_side = RST_ARM_SIDE;
    p_cap = RST_MAX_MOVE;
    p_tmax = RST_MAX_TARGET;
    p_slide_ms = RST_SLIDER_HOLD;
    p_arm_ms = RST_ARM_HOLD;
    st = ST_IDLE;
    {sl_run, arm_run, done_q, sl_dir, arm_dir} = '0;
    {sl_left, arm_left} = '0;
    {sl_at, arm_at, sl_goal, arm_goal} = '0;
    job = '0;
    ms_now = '0;
    t0 = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed pass at reset settings
    push(REQ_READ_CLR, 3'd0, 1'b0);
    push(REQ_TICK, 3'd7, 1'b1);
    push(REQ_UPDATE, 3'd0, 1'b0);
    push(REQ_UNUSED_HI, 3'd7, 1'b1);
    push(REQ_UNUSED_LO, 3'd2, 1'b0);
    push(REQ_SL_STEP, 3'd5, 1'b1);
    push(REQ_ARM_STEP, 3'd0, 1'b0);
    push(REQ_JOG_STOP, 3'd1, 1'b1);
    push(REQ_JOG_START, 3'd0, 1'b1);
    push(REQ_JOG_START, 3'd0, 1'b0);
    push(REQ_SL_STEP, 3'd0, 1'b0);
    push(REQ_START, 3'd1, 1'b0);
    push(REQ_UPDATE, 3'd0, 1'b0);
    push(REQ_JOG_STOP, 3'd0, 1'b0);
    push(REQ_START, 3'd7, 1'b0);
    push(REQ_START, 3'd0, 1'b0);
    push(REQ_UPDATE, 3'd0, 1'b0);
    push(REQ_UPDATE, 3'd0, 1'b0);
    push(REQ_STOP_ALL, 3'd0, 1'b0);
    push(REQ_START, 3'd6, 1'b0);
    push(REQ_START, 3'd2, 1'b1);
    push(REQ_SL_STEP, 3'd0, 1'b0);
    push(REQ_STOP_ALL, 3'd3, 1'b1);
    push(REQ_READ_CLR, 3'd4, 1'b0);
    wait_drain();

    // short moves and holds, no stalls
    load_settings(16'd3, 16'd2, 16'd2, 16'd2, 3'd6, 16'd2, 16'd1);
    calm = 1'b1;
    run_phase(110);
    calm = 1'b0;

    // zero distances: no dropoff move ever starts, target limit above six
    load_settings(16'd0, 16'd0, 16'd0, 16'd65535, 3'd7, 16'd0, 16'd0);
    run_phase(60);

    // huge distances clamped to a zero count
    load_settings(16'd65535, 16'd65535, 16'd65535, 16'd0, 3'd3, 16'd1, 16'd3);
    run_phase(50);

    // arm hold never expires
    load_settings(16'd4, 16'd1, 16'd3, 16'd3, 3'd2, 16'd0, 16'd65535);
    run_phase(40);

    // slider hold never expires
    load_settings(16'd1, 16'd1, 16'd1, 16'd1, 3'd6, 16'd65535, 16'd0);
    run_phase(25);

    repeat (2) begin
      load_settings(16'($urandom_range(20)), 16'($urandom_range(20)),
                    16'($urandom_range(20)), 16'($urandom_range(1, 4)),
                    3'($urandom_range(7)), 16'($urandom_range(3)),
                    16'($urandom_range(3)));
      run_phase(65);
    end

    $display("Checked %0d status items from %0d requests under %0d register settings.",
             checked, taken, settings);
    $display("Dropoffs accepted: %0d; done flags read back set: %0d.", n_accepted, n_done);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d requests queued, %0d taken, %0d results checked",
             queued, taken, checked);
    $display("Mismatches found");
    $finish;
  end

endmodule
